/* hw/rtl/mpkd_pkg.sv */
// Shared types and constants for the Morse paddle keyer and decoder.
// Event codes, timer limits and the fixed Morse code table. No dependencies.
`timescale 1ns / 1ps

package mpkd_pkg;

    localparam int TIMER_W     = 10;
    localparam int THR_W       = 11;
    localparam int DIT_W       = 7;
    localparam int KIND_W      = 3;
    localparam int SYM_W       = 6;
    localparam int TABLE_SLOTS = 64;

    localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};
    localparam logic [DIT_W-1:0]   DIT_RESET = 7'd80;

    localparam logic [1:0] ADDR_DIT_TICKS = 2'd0;

    localparam logic [KIND_W-1:0] EV_DIT     = 3'd0;
    localparam logic [KIND_W-1:0] EV_DAH     = 3'd1;
    localparam logic [KIND_W-1:0] EV_CHAR    = 3'd2;
    localparam logic [KIND_W-1:0] EV_UNKNOWN = 3'd3;
    localparam logic [KIND_W-1:0] EV_WORD    = 3'd4;

    // bit i set means element i is a dah
    typedef struct packed {
        logic [3:0] len;
        logic [7:0] bits;
    } code_entry_t;

    localparam code_entry_t MORSE_TABLE [TABLE_SLOTS] = '{
        0:  '{4'd0, 8'd0},   1:  '{4'd6, 8'd30},  2:  '{4'd6, 8'd45},  3:  '{4'd6, 8'd51},
        4:  '{4'd6, 8'd33},  5:  '{4'd6, 8'd42},  6:  '{4'd5, 8'd9},   7:  '{4'd5, 8'd31},
        8:  '{4'd5, 8'd30},  9:  '{4'd5, 8'd28},  10: '{4'd5, 8'd24},  11: '{4'd5, 8'd16},
        12: '{4'd5, 8'd0},   13: '{4'd5, 8'd1},   14: '{4'd5, 8'd3},   15: '{4'd5, 8'd7},
        16: '{4'd5, 8'd15},  17: '{4'd6, 8'd7},   18: '{4'd6, 8'd21},  19: '{4'd6, 8'd12},
        20: '{4'd2, 8'd2},   21: '{4'd4, 8'd1},   22: '{4'd4, 8'd5},   23: '{4'd3, 8'd1},
        24: '{4'd1, 8'd0},   25: '{4'd4, 8'd4},   26: '{4'd3, 8'd3},   27: '{4'd4, 8'd0},
        28: '{4'd2, 8'd0},   29: '{4'd4, 8'd14},  30: '{4'd3, 8'd5},   31: '{4'd4, 8'd2},
        32: '{4'd2, 8'd3},   33: '{4'd2, 8'd1},   34: '{4'd3, 8'd7},   35: '{4'd4, 8'd6},
        36: '{4'd4, 8'd11},  37: '{4'd3, 8'd2},   38: '{4'd3, 8'd0},   39: '{4'd1, 8'd1},
        40: '{4'd3, 8'd4},   41: '{4'd4, 8'd8},   42: '{4'd3, 8'd6},   43: '{4'd4, 8'd9},
        44: '{4'd4, 8'd13},  45: '{4'd4, 8'd3},   46: '{4'd6, 8'd44},  47: '{4'd8, 8'd0},
        48: '{4'd5, 8'd13},
        default: '{4'd0, 8'd0}
    };

endpackage

/* hw/rtl/morse_paddle_keyer_decoder.sv */
// Morse paddle keyer and decoder top level: tick input register, per-tick keying
// and decode logic, event output register, APB register for the dit length.
// Depends on mpkd_pkg.
`timescale 1ns / 1ps

// One item is one millisecond tick with the two paddle levels. The block takes an
// item every clock cycle while item_stall is low; the tick register captures the
// accepted tick, and the keying and table lookup logic fills the event register from
// it once that register is empty or being taken, so the event (dit, dah, character,
// unrecognised pattern or word gap), if the tick causes one, shows on the event port
// from the event register. That register holds a result while event_stall is high;
// item_stall rises only when a tick is waiting behind a stalled event. The user must
// write dit_ticks (APB address 0) only while idle; the block does not enforce this.
module morse_paddle_keyer_decoder
    import mpkd_pkg::*;
#(
    parameter int MAX_ELEMENTS  = 8,
    parameter int TABLE_ENTRIES = 49
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic              dit_pressed,
    input  logic              dah_pressed,
    output logic              event_valid,
    input  logic              event_stall,
    output logic [KIND_W-1:0] event_kind,
    output logic [SYM_W-1:0]  symbol_index,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [1:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int IDX_W = $clog2(MAX_ELEMENTS);

    logic [DIT_W-1:0]        dit_ticks_reg;
    logic                    tick_valid_reg;
    logic                    tick_dit_reg;
    logic                    tick_dah_reg;
    logic                    ev_valid_reg;
    logic [KIND_W-1:0]       ev_kind_reg;
    logic [SYM_W-1:0]        ev_sym_reg;

    logic [TIMER_W-1:0]      gap_timer_reg,     gap_timer_next;
    logic                    last_was_dit_reg,  last_was_dit_next;
    logic [MAX_ELEMENTS-1:0] element_bits_reg,  element_bits_next;
    logic [CNT_W-1:0]        element_count_reg, element_count_next;
    logic                    overflow_reg,      overflow_next;
    logic                    letter_done_reg,   letter_done_next;
    logic                    word_done_reg,     word_done_next;

    logic                    ev_valid_next;
    logic [KIND_W-1:0]       ev_kind_next;
    logic [SYM_W-1:0]        ev_sym_next;

    logic                    process;
    logic [TIMER_W-1:0]      t_now;
    logic [THR_W-1:0]        thr2, thr4, thr8;
    logic                    eligible, elem_taken;
    logic                    found;
    logic [SYM_W-1:0]        found_idx;

    assign pready = 1'b1;
    assign prdata = {{(32-DIT_W){1'b0}}, dit_ticks_reg};

    assign process    = tick_valid_reg && (!ev_valid_reg || !event_stall);
    assign item_stall = tick_valid_reg && !process;

    assign event_valid  = ev_valid_reg;
    assign event_kind   = ev_kind_reg;
    assign symbol_index = ev_sym_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dit_ticks_reg <= DIT_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr == ADDR_DIT_TICKS)
        begin
            dit_ticks_reg <= pwdata[DIT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            tick_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            tick_dit_reg <= dit_pressed;
            tick_dah_reg <= dah_pressed;
        end
    end

    always_comb
    begin
        t_now = (gap_timer_reg == TIMER_MAX) ? gap_timer_reg : gap_timer_reg + 1'b1;
        thr2  = {{(THR_W-DIT_W-1){1'b0}}, dit_ticks_reg, 1'b0};
        thr4  = {{(THR_W-DIT_W-2){1'b0}}, dit_ticks_reg, 2'b0};
        thr8  = {{(THR_W-DIT_W-3){1'b0}}, dit_ticks_reg, 3'b0};
        eligible = ({1'b0, t_now} >= thr4) || (last_was_dit_reg && ({1'b0, t_now} >= thr2));
        elem_taken = eligible && (tick_dit_reg || tick_dah_reg);
    end

    // lowest matching index wins
    always_comb
    begin
        found     = 1'b0;
        found_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (MORSE_TABLE[i].len != 4'd0 &&
                8'(MORSE_TABLE[i].len) == 8'(element_count_reg) &&
                16'(MORSE_TABLE[i].bits) == 16'(element_bits_reg))
            begin
                found     = 1'b1;
                found_idx = SYM_W'(i);
            end
        end
    end

    always_comb
    begin
        gap_timer_next     = gap_timer_reg;
        last_was_dit_next  = last_was_dit_reg;
        element_bits_next  = element_bits_reg;
        element_count_next = element_count_reg;
        overflow_next      = overflow_reg;
        letter_done_next   = letter_done_reg;
        word_done_next     = word_done_reg;
        ev_valid_next      = ev_valid_reg && event_stall;
        ev_kind_next       = ev_kind_reg;
        ev_sym_next        = ev_sym_reg;

        if (process)
        begin
            gap_timer_next = t_now;
            ev_valid_next  = 1'b0;
            ev_sym_next    = '0;
            if (elem_taken)
            begin
                if (element_count_reg < CNT_W'(MAX_ELEMENTS))
                begin
                    element_bits_next[element_count_reg[IDX_W-1:0]] =
                        element_bits_reg[element_count_reg[IDX_W-1:0]] | !tick_dit_reg;
                    element_count_next = element_count_reg + 1'b1;
                end
                else
                begin
                    overflow_next = 1'b1;
                end
                gap_timer_next    = '0;
                last_was_dit_next = tick_dit_reg;
                letter_done_next  = 1'b0;
                word_done_next    = 1'b0;
                ev_valid_next     = 1'b1;
                ev_kind_next      = tick_dit_reg ? EV_DIT : EV_DAH;
            end
            else if (({1'b0, t_now} >= thr4) && !letter_done_reg)
            begin
                ev_valid_next = 1'b1;
                if (!overflow_reg && found)
                begin
                    ev_kind_next = EV_CHAR;
                    ev_sym_next  = found_idx;
                end
                else
                begin
                    ev_kind_next = EV_UNKNOWN;
                end
                element_bits_next  = '0;
                element_count_next = '0;
                overflow_next      = 1'b0;
                letter_done_next   = 1'b1;
            end
            else if (({1'b0, t_now} >= thr8) && !word_done_reg)
            begin
                ev_valid_next    = 1'b1;
                ev_kind_next     = EV_WORD;
                word_done_next   = 1'b1;
                letter_done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_timer_reg     <= TIMER_MAX;
            last_was_dit_reg  <= 1'b0;
            element_bits_reg  <= '0;
            element_count_reg <= '0;
            overflow_reg      <= 1'b0;
            letter_done_reg   <= 1'b1;
            word_done_reg     <= 1'b1;
            ev_valid_reg      <= 1'b0;
        end
        else
        begin
            gap_timer_reg     <= gap_timer_next;
            last_was_dit_reg  <= last_was_dit_next;
            element_bits_reg  <= element_bits_next;
            element_count_reg <= element_count_next;
            overflow_reg      <= overflow_next;
            letter_done_reg   <= letter_done_next;
            word_done_reg     <= word_done_next;
            ev_valid_reg      <= ev_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_kind_reg <= ev_kind_next;
        ev_sym_reg  <= ev_sym_next;
    end

endmodule

/* hw/rtl/mpkd_checker.sv */
// Port-level checks for the Morse paddle keyer and decoder, bound to the top level.
// Depends on mpkd_pkg and morse_paddle_keyer_decoder.
`timescale 1ns / 1ps

module mpkd_checker
    import mpkd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input logic              event_valid,
    input logic              event_stall,
    input logic [KIND_W-1:0] event_kind,
    input logic [SYM_W-1:0]  symbol_index
);

    a_event_hold: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && event_stall |=>
            event_valid && $stable(event_kind) && $stable(symbol_index))
        else $error("stalled event changed");

    a_sym_zero: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && event_kind != EV_CHAR |-> symbol_index == '0)
        else $error("symbol index set on a non-character event");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> event_valid && event_stall)
        else $error("item stalled without a stalled event");

    a_event_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(event_valid) |-> $past(item_valid && !item_stall, 2))
        else $error("event without an accepted item");

endmodule

bind morse_paddle_keyer_decoder mpkd_checker u_mpkd_checker (.*);

/* bench/morse_event_checker.sv */
// Event checker for the Morse paddle keyer and decoder: watches the tick, event and
// APB channels, predicts each event from the ticks and compares in order.
// Depends on mpkd_pkg for port widths and event codes.
`timescale 1ns / 1ps

module morse_event_checker
    import mpkd_pkg::*;
#(
    parameter logic [1:0] DIT_ADDR = 2'd0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_stall,
    input  logic              dit_pressed,
    input  logic              dah_pressed,
    input  logic              event_valid,
    input  logic              event_stall,
    input  logic [KIND_W-1:0] event_kind,
    input  logic [SYM_W-1:0]  symbol_index,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [1:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    output int                fail_count,
    output int                pending
);

    localparam int         CODE_ENTRIES = 49;
    localparam int         CODE_MAX     = 8;
    localparam logic [9:0] SINCE_MAX    = 10'd1023;
    localparam logic [6:0] DIT_DEFAULT  = 7'd80;

    // bit i of a code set means element i is a dah; entry 0 (space) never matches
    localparam int CODE_LEN [CODE_ENTRIES] = '{
        0, 6, 6, 6, 6, 6, 5, 5, 5, 5, 5, 5, 5, 5, 5, 5,
        5, 6, 6, 6, 2, 4, 4, 3, 1, 4, 3, 4, 2, 4, 3, 4,
        2, 2, 3, 4, 4, 3, 3, 1, 3, 4, 3, 4, 4, 4, 6, 8,
        5
    };
    localparam int CODE_BITS [CODE_ENTRIES] = '{
        0, 30, 45, 51, 33, 42, 9, 31, 30, 28, 24, 16, 0, 1, 3, 7,
        15, 7, 21, 12, 2, 1, 5, 1, 0, 4, 3, 0, 0, 14, 5, 2,
        3, 1, 7, 6, 11, 2, 0, 1, 4, 8, 6, 9, 13, 3, 44, 0,
        13
    };

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SYM_W-1:0]  sym;
    } keyer_ev_t;

    keyer_ev_t  due_events [$];

    logic [6:0] dit_len;
    logic [9:0] since_elem;
    logic       prev_dit;
    logic [7:0] code_bits;
    logic [3:0] code_len;
    logic       code_spill;
    logic       char_closed;
    logic       word_closed;

    task automatic decode_tick(input logic dit, input logic dah);
        keyer_ev_t ev;
        int        t;
        int        i;
        bit        made;
        made = 1'b0;
        ev   = '0;
        if (since_elem != SINCE_MAX)
            since_elem++;
        t = since_elem;
        if ((dit || dah) && (t >= 4 * dit_len || (prev_dit && t >= 2 * dit_len)))
        begin
            ev.kind = dit ? EV_DIT : EV_DAH;
            if (code_len < CODE_MAX)
            begin
                code_bits[code_len] = !dit;
                code_len++;
            end
            else
                code_spill = 1'b1;
            since_elem  = '0;
            prev_dit    = dit;
            char_closed = 1'b0;
            word_closed = 1'b0;
            made        = 1'b1;
        end
        else if (t >= 4 * dit_len && !char_closed)
        begin
            ev.kind = EV_UNKNOWN;
            for (i = 0; i < CODE_ENTRIES; i++)
            begin
                if (!code_spill && ev.kind == EV_UNKNOWN && CODE_LEN[i] != 0 &&
                    CODE_LEN[i] == code_len && CODE_BITS[i] == code_bits)
                begin
                    ev.kind = EV_CHAR;
                    ev.sym  = i[SYM_W-1:0];
                end
            end
            code_bits   = '0;
            code_len    = '0;
            code_spill  = 1'b0;
            char_closed = 1'b1;
            made        = 1'b1;
        end
        else if (t >= 8 * dit_len && !word_closed)
        begin
            ev.kind     = EV_WORD;
            word_closed = 1'b1;
            char_closed = 1'b1;
            made        = 1'b1;
        end
        if (made)
            due_events.push_back(ev);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        keyer_ev_t want;
        if (!rst_n)
        begin
            due_events.delete();
            dit_len     = DIT_DEFAULT;
            since_elem  = SINCE_MAX;
            prev_dit    = 1'b0;
            code_bits   = '0;
            code_len    = '0;
            code_spill  = 1'b0;
            char_closed = 1'b1;
            word_closed = 1'b1;
            fail_count  = 0;
            pending     = 0;
        end
        else
        begin
            if (event_valid && !event_stall)
            begin
                if (due_events.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected event: kind %0d symbol %0d",
                                 $realtime, event_kind, symbol_index);
                end
                else
                begin
                    want = due_events.pop_front();
                    if (event_kind !== want.kind || symbol_index !== want.sym)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: expected kind %0d sym %0d, got kind %0d sym %0d",
                                     $realtime, want.kind, want.sym, event_kind,
                                     symbol_index);
                    end
                end
            end
            if (psel && penable && pwrite && pready && paddr == DIT_ADDR)
                dit_len = pwdata[6:0];
            if (item_valid && !item_stall)
                decode_tick(dit_pressed, dah_pressed);
            pending = due_events.size();
        end
    end

endmodule

/* bench/tb_morse_paddle_keyer_decoder.sv */
// Testbench top for the Morse paddle keyer and decoder: clock, reset, tick stimulus
// with random sender gaps and event stalls, dit length writes over APB, verdict.
// Depends on mpkd_pkg, morse_paddle_keyer_decoder and morse_event_checker.
`timescale 1ns / 1ps

module tb_morse_paddle_keyer_decoder;
    import mpkd_pkg::*;

    localparam logic [1:0] REG_DIT_TICKS = ADDR_DIT_TICKS;
    localparam int         SETTLE_CYCLES = 6;
    localparam int         CYCLE_LIMIT   = 1000000;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              item_valid   = 1'b0;
    logic              item_stall;
    logic              dit_pressed  = 1'b0;
    logic              dah_pressed  = 1'b0;
    logic              event_valid;
    logic              event_stall  = 1'b0;
    logic [KIND_W-1:0] event_kind;
    logic [SYM_W-1:0]  symbol_index;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [1:0]        paddr        = '0;
    logic [31:0]       pwdata       = '0;
    logic [31:0]       prdata;
    logic              pready;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int ticks_sent  = 0;
    int tx_calm     = 0;
    int stall_left  = 0;
    int calm_left   = 0;
    bit tx_idle     = 1'b1;
    bit rx_idle     = 1'b1;

    morse_paddle_keyer_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .dit_pressed  (dit_pressed),
        .dah_pressed  (dah_pressed),
        .event_valid  (event_valid),
        .event_stall  (event_stall),
        .event_kind   (event_kind),
        .symbol_index (symbol_index),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    morse_event_checker #(
        .DIT_ADDR (REG_DIT_TICKS)
    ) event_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .dit_pressed  (dit_pressed),
        .dah_pressed  (dah_pressed),
        .event_valid  (event_valid),
        .event_stall  (event_stall),
        .event_kind   (event_kind),
        .symbol_index (symbol_index),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[morse_paddle_keyer_decoder] ERROR");
            $finish;
        end
    end

    // event stall bursts, with calm stretches in between
    always @(negedge clk)
    begin
        if (!rx_idle)
        begin
            stall_left = 0;
            calm_left  = 0;
        end
        else if (stall_left == 0 && calm_left == 0)
        begin
            stall_left = $urandom_range(1, 17);
            calm_left  = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160)
                                                     : $urandom_range(0, 12);
        end
        event_stall <= (stall_left != 0);
        if (stall_left != 0)
            stall_left--;
        else if (calm_left != 0)
            calm_left--;
    end

    task automatic send_tick(input logic dit, input logic dah);
        if (tx_idle)
        begin
            if (tx_calm > 0)
                tx_calm--;
            else if ($urandom_range(0, 5) == 0)
            begin
                item_valid <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
                if ($urandom_range(0, 3) == 0)
                    tx_calm = $urandom_range(30, 120);
            end
        end
        item_valid  <= 1'b1;
        dit_pressed <= dit;
        dah_pressed <= dah;
        do
            @(posedge clk);
        while (item_stall);
        ticks_sent++;
        @(negedge clk);
    endtask

    // stop sending until every predicted event is out, then let the pipeline empty
    task automatic settle();
        item_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_dit(input logic [6:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_DIT_TICKS;
        pwdata  <= ($urandom & 32'hFFFF_FF80) | {25'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // one pattern (from the table or random) keyed on time: each element pressed once it is
    // eligible, after a dah just as it becomes eligible, then a letter gap or a word gap
    task automatic key_char(input int d);
        int         n;
        int         k;
        int         h;
        int         w;
        int         gap;
        int         pick;
        int         idx;
        logic [9:0] pat;
        logic       is_dah;
        logic       prev_dah;
        logic       both;
        h        = 1;
        prev_dah = 1'b0;
        pick     = $urandom_range(0, 99);
        pat      = 10'($urandom);
        if (d >= 16)
            n = $urandom_range(1, 2);
        else if (pick < 50)
        begin
            idx = $urandom_range(1, 48);
            n   = int'(MORSE_TABLE[idx].len);
            pat = {2'b00, MORSE_TABLE[idx].bits};
        end
        else if (pick < 85)
            n = $urandom_range(1, 6);
        else
            n = $urandom_range(7, 10);
        for (k = 0; k < n; k++)
        begin
            is_dah = pat[k];
            if (k > 0)
            begin
                w = (prev_dah ? 4 * d : $urandom_range(2 * d, 4 * d)) - h;
                if (w > 0)
                    repeat (w) send_tick(1'b0, 1'b0);
            end
            if (d <= 1 || $urandom_range(0, 7) != 0)
                h = 1;
            else
                h = $urandom_range(1, 2 * d - 1);
            both = !is_dah && $urandom_range(0, 4) == 0;
            send_tick(!is_dah, is_dah || both);
            if (h > 1)
                repeat (h - 1) send_tick(!is_dah, is_dah);
            prev_dah = is_dah;
        end
        if ($urandom_range(0, 9) < 6)
            gap = 4 * d + $urandom_range(1, 3 * d + 1);
        else
            gap = 8 * d + $urandom_range(2, 2 * d + 2);
        repeat (gap) send_tick(1'b0, 1'b0);
    endtask

    // random paddle levels, early presses and both paddles, then a quiet stretch
    task automatic scramble(input int d);
        int         n;
        int         k;
        logic [1:0] lv;
        n = $urandom_range(1, 4 * d + 6);
        for (k = 0; k < n; k++)
        begin
            lv = ($urandom_range(0, 1) == 0) ? 2'b00 : 2'($urandom_range(0, 3));
            send_tick(lv[1], lv[0]);
        end
        repeat (4 * d + 1) send_tick(1'b0, 1'b0);
    endtask

    task automatic run_keying(input int d, input int budget);
        int first;
        bit paused;
        settle();
        write_dit(d[6:0]);
        first  = ticks_sent;
        paused = 1'b0;
        while (ticks_sent - first < budget)
        begin
            if (!paused && ticks_sent - first >= budget / 2)
            begin
                settle();
                paused = 1'b1;
            end
            if (d < 16 && $urandom_range(0, 6) == 0)
                scramble(d);
            else
                key_char(d);
        end
    endtask

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset dit length: nothing before the first element, then one dah
        repeat (3) send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        repeat (660) send_tick(1'b0, 1'b0);

        // zero dit length: every tick is eligible
        settle();
        write_dit(7'd0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        repeat (3) send_tick(1'b0, 1'b0);
        repeat (8) send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        repeat (9) send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);

        run_keying(1, 100);
        run_keying(2, 100);
        run_keying(3, 100);
        run_keying(5, 100);
        run_keying(0, 100);
        run_keying(4, 100);
        run_keying(48, 1);

        tx_idle = 1'b0;
        rx_idle <= 1'b0;
        run_keying(2, 100);
        settle();

        if (fail_count == 0 && pending == 0)
            $display("[morse_paddle_keyer_decoder] OK");
        else
            $display("[morse_paddle_keyer_decoder] ERROR");
        $finish;
    end

endmodule
